### hdl/incremental_pid_clamped_core_assert.svh
// Assertion macros used by the incremental PID core.
`ifndef INCREMENTAL_PID_CLAMPED_CORE_ASSERT_SVH
`define INCREMENTAL_PID_CLAMPED_CORE_ASSERT_SVH

// Concurrent check clocked on the rising edge, disabled while reset is asserted.
`define IPIDC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check that a condition never holds at a clock edge.
`define IPIDC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hdl/ipidc_pkg.sv
// Package with types, register indexes and reset values of the incremental PID core.
`timescale 1ns / 1ps

package ipidc_pkg;

	localparam int ACC_WIDTH_DEF  = 32;
	localparam int MEAS_WIDTH_DEF = 16;
	localparam int REG_W          = 16;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SETPOINT = 3'd0,
		REG_COEF_A   = 3'd1,
		REG_COEF_B   = 3'd2,
		REG_COEF_C   = 3'd3,
		REG_OUT_MAX  = 3'd4,
		REG_OUT_MIN  = 3'd5
	} reg_idx_t;

	localparam logic        [REG_W-1:0] SETPOINT_RST = 16'd9000;
	localparam logic signed [REG_W-1:0] COEF_A_RST   = 16'sd240;
	localparam logic signed [REG_W-1:0] COEF_B_RST   = -16'sd210;
	localparam logic signed [REG_W-1:0] COEF_C_RST   = 16'sd10;
	localparam logic        [REG_W-1:0] OUT_MAX_RST  = 16'd31;
	localparam logic        [REG_W-1:0] OUT_MIN_RST  = 16'd0;

	typedef struct packed {
		logic        [REG_W-1:0] setpoint;
		logic signed [REG_W-1:0] coef_a;
		logic signed [REG_W-1:0] coef_b;
		logic signed [REG_W-1:0] coef_c;
		logic        [REG_W-1:0] out_max;
		logic        [REG_W-1:0] out_min;
	} cfg_t;

endpackage

### hdl/ipidc_cfg.sv
// Configuration register bank of the incremental PID core.
`timescale 1ns / 1ps

module ipidc_cfg
	import ipidc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Writes are taken in any cycle; the bank never holds a write off.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_RST;
			cfg_q.coef_a   <= COEF_A_RST;
			cfg_q.coef_b   <= COEF_B_RST;
			cfg_q.coef_c   <= COEF_C_RST;
			cfg_q.out_max  <= OUT_MAX_RST;
			cfg_q.out_min  <= OUT_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SETPOINT: cfg_q.setpoint <= cfg_data;
				REG_COEF_A:   cfg_q.coef_a   <= signed'(cfg_data);
				REG_COEF_B:   cfg_q.coef_b   <= signed'(cfg_data);
				REG_COEF_C:   cfg_q.coef_c   <= signed'(cfg_data);
				REG_OUT_MAX:  cfg_q.out_max  <= cfg_data;
				REG_OUT_MIN:  cfg_q.out_min  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

### hdl/incremental_pid_clamped_core.sv
// Incremental PID core: usage and handshake notes below.
// Input channel: in_valid / in_stall with one measurement per beat. Output channel:
// out_valid / out_stall with one clamped drive value per beat. A beat moves when valid
// is high and stall is low at a rising clock edge.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. Registers are setpoint, coef_a, coef_b, coef_c, out_max and out_min (index 0..5);
// other indexes are ignored. Write them only while no sample is in flight.
// The accepting edge loads the error, which then passes through the products,
// accumulate and clamp registers before the drive value shows on the output port.
// Throughput: one sample per cycle without stalls. The stored accumulator feeds back
// through a single four-input add in the accumulate stage, which is what sets that rate.
// Each stage moves forward when the stage after it is empty or emptying, so bubbles
// close up and the output register holds a result while earlier stages keep filling.
// When the receiver stalls long enough to fill all four stages, in_stall rises.
// Reset clears the error history, the stored accumulator and all stage valids, and
// loads the register defaults (setpoint 9000, gains 240, -210, 10, limits 0..31).
`timescale 1ns / 1ps
`include "incremental_pid_clamped_core_assert.svh"

module incremental_pid_clamped_core
	import ipidc_pkg::*;
#(
	parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
	parameter int MEAS_WIDTH = MEAS_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [MEAS_WIDTH-1:0] measurement,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [REG_W-1:0]      drive,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]      cfg_data
);

	localparam int ERR_W  = ((MEAS_WIDTH > REG_W) ? MEAS_WIDTH : REG_W) + 1;
	localparam int PROD_W = REG_W + ERR_W;
	localparam int SUM_W  = (ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W;

	cfg_t cfg;

	ipidc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage control
	logic vld_s1, vld_s2, vld_s3, out_valid_q;
	logic can_o, can_s3, can_s2, can_s1;
	logic move_s1, move_s2, move_s3, accept, deliver;

	assign can_o   = !out_valid_q || !out_stall;
	assign move_s3 = vld_s3 && can_o;
	assign can_s3  = !vld_s3 || can_o;
	assign move_s2 = vld_s2 && can_s3;
	assign can_s2  = !vld_s2 || can_s3;
	assign move_s1 = vld_s1 && can_s2;
	assign can_s1  = !vld_s1 || can_s2;

	assign in_stall  = !can_s1;
	assign accept    = in_valid && can_s1;
	assign deliver   = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1      <= accept  || (vld_s1 && !move_s1);
			vld_s2      <= move_s1 || (vld_s2 && !move_s2);
			vld_s3      <= move_s2 || (vld_s3 && !move_s3);
			out_valid_q <= move_s3 || (out_valid_q && !deliver);
		end
	end

	// Stage 1: error of the incoming sample
	logic signed [ERR_W-1:0] err_d, err_s1;

	assign err_d = signed'(ERR_W'(cfg.setpoint) - ERR_W'(measurement));

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1 <= err_d;
		end
	end

	// Stage 2: the three gain products, with the error history shifting as they form
	logic signed [ERR_W-1:0]  e1_q, e2_q;
	logic signed [PROD_W-1:0] prod_a_d, prod_b_d, prod_c_d;
	logic signed [PROD_W-1:0] prod_a_s2, prod_b_s2, prod_c_s2;

	assign prod_a_d = cfg.coef_a * err_s1;
	assign prod_b_d = cfg.coef_b * e1_q;
	assign prod_c_d = cfg.coef_c * e2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q <= '0;
			e2_q <= '0;
		end else if (move_s1) begin
			e1_q <= err_s1;
			e2_q <= e1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			prod_a_s2 <= prod_a_d;
			prod_b_s2 <= prod_b_d;
			prod_c_s2 <= prod_c_d;
		end
	end

	// Stage 3: wrapping accumulate; the unclamped sum is kept for the next sample
	logic signed [ACC_WIDTH-1:0] prev_q, acc_d, acc_s3;
	logic signed [SUM_W-1:0]     acc_sum;

	assign acc_sum = SUM_W'(prev_q) + SUM_W'(prod_a_s2) + SUM_W'(prod_b_s2)
		+ SUM_W'(prod_c_s2);
	assign acc_d   = signed'(acc_sum[ACC_WIDTH-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (move_s2) begin
			prev_q <= acc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			acc_s3 <= acc_d;
		end
	end

	// Output stage: clamp, upper limit tested first so inverted limits favor out_max
	logic signed [ACC_WIDTH-1:0] hi_ext, lo_ext;
	logic        [REG_W-1:0]     drive_d, drive_q;

	assign hi_ext = signed'(ACC_WIDTH'(cfg.out_max));
	assign lo_ext = signed'(ACC_WIDTH'(cfg.out_min));

	always_comb begin
		priority if (acc_s3 > hi_ext) begin
			drive_d = cfg.out_max;
		end else if (acc_s3 < lo_ext) begin
			drive_d = cfg.out_min;
		end else begin
			drive_d = acc_s3[REG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (move_s3) begin
			drive_q <= drive_d;
		end
	end

	assign drive = drive_q;

	// Checks
	`IPIDC_ASSERT(a_hist_shift, clk, arst_n, move_s1 |=> (e1_q == $past(err_s1)),
		"error history did not take the advancing error")
	`IPIDC_ASSERT(a_acc_store, clk, arst_n, move_s2 |=> (prev_q == acc_s3),
		"stored accumulator differs from the value sent to the clamp stage")
	`IPIDC_ASSERT(a_occupancy, clk, arst_n, (accept && !deliver) |=>
		($countones({vld_s1, vld_s2, vld_s3, out_valid_q})
		== $past($countones({vld_s1, vld_s2, vld_s3, out_valid_q})) + 1),
		"pipeline occupancy did not grow by one on an input beat")
	`IPIDC_ASSERT_NEVER(a_no_overrun, clk, arst_n, vld_s3 && !can_s3 && move_s2,
		"stage two overwrote a held accumulate result")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the incremental PID core with clamped drive output.
`timescale 1ns / 1ps

module tb;
	import ipidc_pkg::*;

	localparam int ACC_W        = ACC_WIDTH_DEF;
	localparam int MEAS_W       = MEAS_WIDTH_DEF;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_ITEMS   = 115;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [MEAS_W-1:0]     measurement = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [REG_W-1:0]      drive;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [REG_W-1:0]      cfg_data    = '0;

	// Predictor copy of the configuration and of the controller state.
	logic        [REG_W-1:0] pred_setpoint;
	logic signed [REG_W-1:0] pred_coef_a;
	logic signed [REG_W-1:0] pred_coef_b;
	logic signed [REG_W-1:0] pred_coef_c;
	logic        [REG_W-1:0] pred_out_max;
	logic        [REG_W-1:0] pred_out_min;
	longint                  pred_acc;
	longint                  pred_err1;
	longint                  pred_err2;

	logic [MEAS_W-1:0] meas_q[$];
	logic [REG_W-1:0]  drive_exp_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen;
	int hold_left;
	int mismatches     = 0;
	int samples_sent   = 0;
	int drives_checked = 0;
	int configs_used   = 0;
	int cycle_count    = 0;

	incremental_pid_clamped_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Advances the controller by one sample and returns the clamped drive value.
	function automatic logic [REG_W-1:0] pid_next_drive(input logic [MEAS_W-1:0] meas);
		longint          err;
		longint          sum;
		logic [ACC_W-1:0] wrapped;
		longint          acc;
		longint          hi;
		longint          lo;
		longint          clamped;
		err     = longint'(pred_setpoint) - longint'(meas);
		sum     = pred_acc + longint'(pred_coef_a) * err + longint'(pred_coef_b) * pred_err1
			+ longint'(pred_coef_c) * pred_err2;
		wrapped = sum[ACC_W-1:0];
		acc     = longint'($signed(wrapped));
		pred_err2 = pred_err1;
		pred_err1 = err;
		pred_acc  = acc;
		hi = longint'(pred_out_max);
		lo = longint'(pred_out_min);
		// The upper limit wins when the limits are inverted.
		if (acc > hi)
			clamped = hi;
		else if (acc < lo)
			clamped = lo;
		else
			clamped = acc;
		return clamped[REG_W-1:0];
	endfunction

	function automatic void pred_write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] data);
		case (idx)
			REG_SETPOINT: pred_setpoint = data;
			REG_COEF_A:   pred_coef_a   = data;
			REG_COEF_B:   pred_coef_b   = data;
			REG_COEF_C:   pred_coef_c   = data;
			REG_OUT_MAX:  pred_out_max  = data;
			REG_OUT_MIN:  pred_out_min  = data;
			default: ;
		endcase
	endfunction

	// Input driver: offers queued samples and predicts each accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			measurement <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				drive_exp_q.push_back(pid_next_drive(measurement));
				samples_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (meas_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid    <= 1'b1;
					measurement <= meas_q.pop_front();
				end else begin
					in_valid    <= 1'b0;
					measurement <= MEAS_W'($urandom);
				end
			end
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Output monitor: checks each drive beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drive_exp_q.size() == 0) begin
					report_mismatch($sformatf("drive beat 0x%04h with no sample pending", drive));
				end else begin
					logic [REG_W-1:0] want;
					want = drive_exp_q.pop_front();
					if (drive !== want)
						report_mismatch($sformatf("drive 0x%04h, expected 0x%04h", drive, want));
				end
				drives_checked++;
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		pred_write_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [REG_W-1:0] sp, input logic [REG_W-1:0] ca,
		input logic [REG_W-1:0] cb, input logic [REG_W-1:0] cc,
		input logic [REG_W-1:0] hi, input logic [REG_W-1:0] lo);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_COEF_A, ca);
		write_reg(REG_COEF_B, cb);
		write_reg(REG_COEF_C, cc);
		write_reg(REG_OUT_MAX, hi);
		write_reg(REG_OUT_MIN, lo);
		configs_used++;
	endtask

	// Waits until every sample has gone through, then lets the pipeline settle.
	task automatic wait_drained();
		while (meas_q.size() != 0 || in_valid || drive_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_load(input int idle_pct, input int stall_pct);
		@(posedge clk);
		send_idle_pct  <= idle_pct;
		recv_stall_pct <= stall_pct;
	endtask

	function automatic logic [REG_W-1:0] rand_coef();
		if ($urandom_range(3) == 0)
			return REG_W'($urandom);
		return REG_W'(int'($urandom_range(600)) - 300);
	endfunction

	function automatic logic [REG_W-1:0] rand_limit();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return REG_W'($urandom);
		endcase
	endfunction

	task automatic random_config();
		logic [REG_W-1:0] sp;
		logic [REG_W-1:0] a;
		logic [REG_W-1:0] b;
		case ($urandom_range(7))
			0: sp = '0;
			1: sp = '1;
			default: sp = REG_W'($urandom);
		endcase
		a = rand_limit();
		b = rand_limit();
		// Mostly ordered limits; now and then inverted on purpose.
		if ($urandom_range(4) != 0 && a < b)
			write_all(sp, rand_coef(), rand_coef(), rand_coef(), b, a);
		else
			write_all(sp, rand_coef(), rand_coef(), rand_coef(), a, b);
	endtask

	task automatic queue_random(input int n);
		int m;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(1) == 0) begin
				m = int'(pred_setpoint) + int'($urandom_range(400)) - 200;
				if (m < 0)
					m = 0;
				if (m > 65535)
					m = 65535;
				meas_q.push_back(MEAS_W'(m));
			end else begin
				meas_q.push_back(MEAS_W'($urandom));
			end
		end
	endtask

	initial begin
		int loads_idle[4];
		int loads_stall[4];
		loads_idle  = '{0, 78, 0, 13};
		loads_stall = '{0, 0, 78, 13};

		pred_setpoint = SETPOINT_RST;
		pred_coef_a   = COEF_A_RST;
		pred_coef_b   = COEF_B_RST;
		pred_coef_c   = COEF_C_RST;
		pred_out_max  = OUT_MAX_RST;
		pred_out_min  = OUT_MIN_RST;
		pred_acc      = 0;
		pred_err1     = 0;
		pred_err2     = 0;
		configs_used  = 1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset defaults: zero error, extreme measurements, small steps around the setpoint.
		meas_q = '{16'd9000, 16'd0, 16'hFFFF, 16'd9001, 16'd8999, 16'd9000, 16'd9000,
			16'd1, 16'h8000, 16'hFFFE};
		wait_drained();

		// Extreme gains and setpoint make the accumulator wrap within a few samples.
		write_all(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000);
		meas_q = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		wait_drained();

		// Inverted limits, then writes to unused indexes that must change nothing.
		write_all(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'd1000, 16'd5000);
		meas_q = '{16'd500, 16'd600, 16'd3};
		wait_drained();
		write_reg(IDX_SPARE_LO, 16'hFFFF);
		write_reg(IDX_SPARE_HI, 16'h1234);
		meas_q = '{16'd7, 16'hFFFF, 16'd0};
		wait_drained();

		for (int k = 0; k < 8; k++) begin
			random_config();
			set_load(loads_idle[k / 2], loads_stall[k / 2]);
			queue_random(RAND_ITEMS);
			wait_drained();
		end

		// Hold the output off long enough for the pipeline to fill and stall its input.
		random_config();
		set_load(0, 0);
		hold_req <= hold_req + 1;
		queue_random(40);
		wait_drained();

		if (drive_exp_q.size() != 0)
			report_mismatch($sformatf("%0d drive values never arrived", drive_exp_q.size()));
		$display("Sent %0d samples under %0d register settings, checked %0d drive values.",
			samples_sent, configs_used, drives_checked);
		$display("Covered wrap-around, inverted limits, unused indexes and long back-pressure.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/ipidc_pkg.sv
hdl/ipidc_cfg.sv
hdl/incremental_pid_clamped_core.sv
tb/sv/tb.sv
